### design/arp_cache_lru_table_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef ARP_CACHE_LRU_TABLE_MACROS_SVH
`define ARP_CACHE_LRU_TABLE_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define ALC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define ALC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/alc_pkg.sv
package alc_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int KIND_W = 2;
   localparam int IP_W   = 32;
   localparam int MAC_W  = 48;
   localparam int AGE_W  = 32;
   localparam int USED_W = 5;

   // Item kinds. The fourth code is unused and changes nothing.
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   typedef enum logic [1:0] {
      WSRC_HIT,
      WSRC_APPEND,
      WSRC_MOVE
   } wsrc_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_HIT,
      ST_APPEND,
      ST_EV_START,
      ST_EV_SCAN,
      ST_MV_RD,
      ST_MV_WR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic     load_key;
      logic     scan_start;
      logic     scan_run;
      logic     min_track;
      logic     rd_last;
      logic     wr_ip;
      logic     wr_mac;
      logic     wr_age;
      wsrc_type wsrc;
      logic     tick_inc;
      logic     cnt_inc;
      logic     cnt_full_m1;
      logic     clear;
      logic     rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              cnt_zero;
      logic              cnt_full;
      logic              match;
      logic              last;
   } dp_sts_type;

endpackage

### design/alc_datapath.sv
module alc_datapath #(
   parameter int TABLE_DEPTH = alc_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [alc_pkg::KIND_W-1:0] req_kind,
   input  logic [alc_pkg::IP_W-1:0]   req_ip_addr,
   input  logic [alc_pkg::MAC_W-1:0]  req_mac_addr,
   input  alc_pkg::dp_cmd_type        cmd,
   output alc_pkg::dp_sts_type        sts,
   output logic                       rsp_found,
   output logic [alc_pkg::MAC_W-1:0]  rsp_mac_result,
   output logic [alc_pkg::USED_W-1:0] rsp_entries_used
);
   import alc_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_FULL_M1 = CNT_W'(TABLE_DEPTH - 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

   logic [IP_W-1:0]  ip_mem  [TABLE_DEPTH];
   logic [MAC_W-1:0] mac_mem [TABLE_DEPTH];
   logic [AGE_W-1:0] age_mem [TABLE_DEPTH];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [AGE_W-1:0]  tick_ff, tick_in;
   logic              pend_ff, pend_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [IDX_W-1:0]  pend_idx_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic [IDX_W-1:0]  victim_ff;
   logic [AGE_W-1:0]  min_age_ff;
   logic [KIND_W-1:0] key_kind_ff;
   logic [IP_W-1:0]   key_ip_ff;
   logic [MAC_W-1:0]  key_mac_ff;
   logic              work_found_ff;
   logic [MAC_W-1:0]  work_mac_ff;
   logic [IP_W-1:0]   rd_ip_ff;
   logic [MAC_W-1:0]  rd_mac_ff;
   logic [AGE_W-1:0]  rd_age_ff;
   logic              rsp_found_ff;
   logic [MAC_W-1:0]  rsp_mac_ff;
   logic [USED_W-1:0] rsp_used_ff;

   logic              issue;
   logic              hit_take;
   logic              min_take;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  wr_addr;
   logic [IP_W-1:0]   wr_ip_data;
   logic [MAC_W-1:0]  wr_mac_data;
   logic [AGE_W-1:0]  wr_age_data;
   logic [AGE_W-1:0]  tick_next;
   logic [31:0]       count_wide;

   assign issue     = (scan_ff < count_ff);
   assign tick_next = tick_ff + AGE_W'(1);
   assign rd_addr   = cmd.rd_last ? IDX_LAST : scan_ff[IDX_W-1:0];

   assign sts.kind     = key_kind_ff;
   assign sts.cnt_zero = (count_ff == '0);
   assign sts.cnt_full = (count_ff == CNT_FULL);
   assign sts.match    = pend_ff && (rd_ip_ff == key_ip_ff);
   assign sts.last     = pend_ff && (CNT_W'(pend_idx_ff) == (count_ff - CNT_W'(1)));

   assign hit_take = cmd.scan_run && !cmd.min_track && sts.match;
   assign min_take = cmd.scan_run && cmd.min_track && pend_ff &&
                     ((pend_idx_ff == '0) || (rd_age_ff < min_age_ff));

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.cnt_full_m1) begin
         count_in = CNT_FULL_M1;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      tick_in = tick_ff;
      if (cmd.clear) begin
         tick_in = '0;
      end else if (cmd.tick_inc) begin
         tick_in = tick_next;
      end
   end

   always_comb begin
      scan_in = scan_ff;
      pend_in = 1'b0;
      if (cmd.scan_start) begin
         scan_in = '0;
      end else if (cmd.scan_run && issue) begin
         scan_in = scan_ff + CNT_W'(1);
         pend_in = 1'b1;
      end
   end

   always_comb begin
      case (cmd.wsrc)
         WSRC_HIT: begin
            wr_addr = hit_idx_ff;
         end
         WSRC_APPEND: begin
            wr_addr = count_ff[IDX_W-1:0];
         end
         WSRC_MOVE: begin
            wr_addr = victim_ff;
         end
         default: begin
            wr_addr = hit_idx_ff;
         end
      endcase
   end

   // A move copies the last entry, just read, into the evicted slot.
   assign wr_ip_data  = (cmd.wsrc == WSRC_MOVE) ? rd_ip_ff  : key_ip_ff;
   assign wr_mac_data = (cmd.wsrc == WSRC_MOVE) ? rd_mac_ff : key_mac_ff;
   assign wr_age_data = (cmd.wsrc == WSRC_MOVE) ? rd_age_ff : tick_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         tick_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         tick_ff  <= tick_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ip_ff  <= ip_mem[rd_addr];
      rd_mac_ff <= mac_mem[rd_addr];
      rd_age_ff <= age_mem[rd_addr];
      if (cmd.wr_ip) begin
         ip_mem[wr_addr] <= wr_ip_data;
      end
      if (cmd.wr_mac) begin
         mac_mem[wr_addr] <= wr_mac_data;
      end
      if (cmd.wr_age) begin
         age_mem[wr_addr] <= wr_age_data;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      pend_idx_ff <= scan_ff[IDX_W-1:0];
      if (cmd.load_key) begin
         key_kind_ff   <= req_kind;
         key_ip_ff     <= req_ip_addr;
         key_mac_ff    <= req_mac_addr;
         work_found_ff <= 1'b0;
         work_mac_ff   <= '0;
      end else if (hit_take) begin
         work_found_ff <= 1'b1;
         work_mac_ff   <= (key_kind_ff == KIND_LOOKUP) ? rd_mac_ff : '0;
      end
      if (hit_take) begin
         hit_idx_ff <= pend_idx_ff;
      end
      if (min_take) begin
         min_age_ff <= rd_age_ff;
         victim_ff  <= pend_idx_ff;
      end
   end

   assign count_wide = 32'(count_ff);

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_found_ff <= work_found_ff;
         rsp_mac_ff   <= work_mac_ff;
         rsp_used_ff  <= count_wide[USED_W-1:0];
      end
   end

   assign rsp_found        = rsp_found_ff;
   assign rsp_mac_result   = rsp_mac_ff;
   assign rsp_entries_used = rsp_used_ff;

endmodule

### design/alc_controller.sv
module alc_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  alc_pkg::dp_sts_type sts,
   output alc_pkg::dp_cmd_type cmd
);
   import alc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (sts.kind)
               KIND_LOOKUP: begin
                  state_in = sts.cnt_zero ? ST_FINISH : ST_SCAN;
               end
               KIND_INSERT: begin
                  state_in = sts.cnt_zero ? ST_APPEND : ST_SCAN;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_SCAN: begin
            if (sts.match) begin
               state_in = ST_HIT;
            end else if (sts.last) begin
               if (sts.kind == KIND_INSERT) begin
                  state_in = sts.cnt_full ? ST_EV_START : ST_APPEND;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_HIT: begin
            state_in = ST_FINISH;
         end
         ST_APPEND: begin
            state_in = ST_FINISH;
         end
         ST_EV_START: begin
            state_in = ST_EV_SCAN;
         end
         ST_EV_SCAN: begin
            if (sts.last) begin
               state_in = ST_MV_RD;
            end
         end
         ST_MV_RD: begin
            state_in = ST_MV_WR;
         end
         ST_MV_WR: begin
            state_in = ST_APPEND;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd      = '0;
      cmd.wsrc = WSRC_HIT;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_key = req_valid;
         end
         ST_DISPATCH: begin
            case (sts.kind)
               KIND_LOOKUP, KIND_INSERT: begin
                  cmd.scan_start = !sts.cnt_zero;
               end
               KIND_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
         end
         ST_HIT: begin
            cmd.wr_age   = 1'b1;
            cmd.wr_mac   = (sts.kind == KIND_INSERT);
            cmd.wsrc     = WSRC_HIT;
            cmd.tick_inc = 1'b1;
         end
         ST_APPEND: begin
            cmd.wr_ip    = 1'b1;
            cmd.wr_mac   = 1'b1;
            cmd.wr_age   = 1'b1;
            cmd.wsrc     = WSRC_APPEND;
            cmd.tick_inc = 1'b1;
            cmd.cnt_inc  = 1'b1;
         end
         ST_EV_START: begin
            cmd.scan_start = 1'b1;
         end
         ST_EV_SCAN: begin
            cmd.scan_run  = 1'b1;
            cmd.min_track = 1'b1;
         end
         ST_MV_RD: begin
            cmd.rd_last = 1'b1;
         end
         ST_MV_WR: begin
            cmd.wr_ip       = 1'b1;
            cmd.wr_mac      = 1'b1;
            cmd.wr_age      = 1'b1;
            cmd.wsrc        = WSRC_MOVE;
            cmd.cnt_full_m1 = 1'b1;
         end
         ST_FINISH: begin
            cmd.rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### design/arp_cache_lru_table.sv
// Channel   Direction  Ports
// req       in         req_valid, req_ready, req_kind, req_ip_addr, req_mac_addr
// rsp       out        rsp_valid, rsp_ready, rsp_found, rsp_mac_result, rsp_entries_used
//
// One item is worked on at a time; each item gives exactly one result item.
// A lookup or insert with N valid entries scans them one entry per cycle
// through the single read port of the tables.
// An insert into a full table adds an age scan and a move.
// Synchronous active-high reset empties the table.
// A held result does not block acceptance; it only stalls the next finish.
module arp_cache_lru_table #(
   parameter int TABLE_DEPTH = alc_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [alc_pkg::KIND_W-1:0] req_kind,
   input  logic [alc_pkg::IP_W-1:0]   req_ip_addr,
   input  logic [alc_pkg::MAC_W-1:0]  req_mac_addr,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_found,
   output logic [alc_pkg::MAC_W-1:0]  rsp_mac_result,
   output logic [alc_pkg::USED_W-1:0] rsp_entries_used
);
   import alc_pkg::*;

   // The controller sequences the scans and writes; the datapath holds the
   // entry tables, the count, the tick and the result register.
   dp_cmd_type cmd;
   dp_sts_type sts;

   alc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Entries live in three memories with registered reads. A scan issues
   // one address per cycle and compares the data in the next cycle.
   // Eviction picks the smallest age, lowest index on ties, then moves the
   // last entry into the freed slot before the new entry is appended.
   alc_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req_kind),
      .req_ip_addr      (req_ip_addr),
      .req_mac_addr     (req_mac_addr),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_found        (rsp_found),
      .rsp_mac_result   (rsp_mac_result),
      .rsp_entries_used (rsp_entries_used)
   );

endmodule

### design/alc_checker.sv
`include "arp_cache_lru_table_macros.svh"

module alc_checker #(
   parameter int TABLE_DEPTH = alc_pkg::DEPTH_DEFAULT
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_found,
   input logic [alc_pkg::MAC_W-1:0]  rsp_mac_result,
   input logic [alc_pkg::USED_W-1:0] rsp_entries_used
);
   import alc_pkg::*;

   // Only a lookup hit returns a MAC address.
   `ALC_ASSERT_NOW(a_mac_zero_on_miss, rsp_valid && !rsp_found, rsp_mac_result == '0, "mac without hit")

   // The count never exceeds the table size while it fits in the field.
   `ALC_ASSERT_NOW(a_used_bound, rsp_valid, (TABLE_DEPTH >= 32) || (32'(rsp_entries_used) <= 32'(TABLE_DEPTH)), "count too large")

   // An accepted item keeps the block busy for at least the next cycle.
   `ALC_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")

   // A stalled result item holds.
   `ALC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_mac_result) && $stable(rsp_entries_used), "result changed")

endmodule

bind arp_cache_lru_table alc_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_alc_checker (.*);
